// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the deframer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

// File: rtl/tlfd_pkg.sv
// ----------------------------------------------------------------------------
// tlfd_pkg
// Types and constants shared by the type-length frame deframer modules.
// ----------------------------------------------------------------------------
package tlfd_pkg;

    localparam logic [7:0]  KIND_DATA        = 8'd1;
    localparam logic [7:0]  KIND_RESIZE      = 8'd2;
    localparam logic [7:0]  KIND_PING        = 8'd4;
    localparam logic [2:0]  HDR_LAST_IDX     = 3'd4;
    localparam logic [2:0]  SIZE_BYTES       = 3'd4;
    localparam logic [31:0] LEN_LIMIT_RST    = 32'd1048576;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        EV_DATA   = 2'd0,
        EV_RESIZE = 2'd1,
        EV_PING   = 2'd2,
        EV_ERROR  = 2'd3
    } t_event;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data_byte;
        logic        data_last;
        logic [15:0] columns;
        logic [15:0] rows;
    } t_result;

endpackage

// File: rtl/tlfd_front.sv
// ----------------------------------------------------------------------------
// tlfd_front
// Header parser and frame classifier: takes one byte per transfer and
// produces at most one result record for the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlfd_front
    import tlfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    output logic        o_push,
    output t_result     o_result
);

    logic        r_in_payload, n_in_payload;
    logic [2:0]  r_hdr_idx,    n_hdr_idx;
    logic [7:0]  r_kind,       n_kind;
    logic [31:0] r_remaining,  n_remaining;
    logic [2:0]  r_pos,        n_pos;
    logic [31:0] r_capture,    n_capture;
    logic [31:0] r_len_limit;

    logic [31:0] w_len;
    logic [31:0] w_rem_dec;

    assign w_len     = {r_remaining[23:0], i_in_byte};
    assign w_rem_dec = r_remaining - 32'd1;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_idx    = r_hdr_idx;
        n_kind       = r_kind;
        n_remaining  = r_remaining;
        n_pos        = r_pos;
        n_capture    = r_capture;
        o_push       = 1'b0;
        o_result     = '0;
        if (i_accept) begin
            if (!r_in_payload) begin
                if (r_hdr_idx == 3'd0) begin
                    n_kind      = i_in_byte;
                    n_remaining = '0;
                    n_hdr_idx   = 3'd1;
                end else begin
                    n_remaining = w_len;
                    if (r_hdr_idx != HDR_LAST_IDX) begin
                        n_hdr_idx = r_hdr_idx + 3'd1;
                    end else begin
                        n_hdr_idx = 3'd0;
                        n_pos     = 3'd0;
                        n_capture = '0;
                        if (w_len > r_len_limit) begin
                            o_push      = 1'b1;
                            o_result.ev = EV_ERROR;
                        end else if (w_len == 32'd0) begin
                            // Empty frame ends here; only a ping has something to say.
                            if (r_kind == KIND_PING) begin
                                o_push      = 1'b1;
                                o_result.ev = EV_PING;
                            end
                        end else begin
                            n_in_payload = 1'b1;
                        end
                    end
                end
            end else begin
                n_remaining = w_rem_dec;
                if (r_kind == KIND_DATA) begin
                    o_push             = 1'b1;
                    o_result.ev        = EV_DATA;
                    o_result.data_byte = i_in_byte;
                    o_result.data_last = (w_rem_dec == 32'd0);
                    if (w_rem_dec == 32'd0) begin
                        n_in_payload = 1'b0;
                    end
                end else begin
                    if (r_pos < SIZE_BYTES) begin
                        n_capture = {r_capture[23:0], i_in_byte};
                        n_pos     = r_pos + 3'd1;
                    end
                    if (w_rem_dec == 32'd0) begin
                        n_in_payload = 1'b0;
                        if (r_kind == KIND_RESIZE && n_pos >= SIZE_BYTES) begin
                            o_push           = 1'b1;
                            o_result.ev      = EV_RESIZE;
                            o_result.columns = n_capture[31:16];
                            o_result.rows    = n_capture[15:0];
                        end else if (r_kind == KIND_PING) begin
                            o_push      = 1'b1;
                            o_result.ev = EV_PING;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_idx    <= '0;
            r_kind       <= '0;
            r_remaining  <= '0;
            r_pos        <= '0;
            r_capture    <= '0;
            r_len_limit  <= LEN_LIMIT_RST;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_idx    <= n_hdr_idx;
            r_kind       <= n_kind;
            r_remaining  <= n_remaining;
            r_pos        <= n_pos;
            r_capture    <= n_capture;
            if (i_cfg_we) begin
                r_len_limit <= i_cfg_wdata;
            end
        end
    end

    // A frame in its payload always has bytes still to come.
    `ASSERT_IMPLY(a_payload_nonzero, i_clk, i_rst_n, r_in_payload, r_remaining != 32'd0)
    // The header counter is idle while payload bytes are taken.
    `ASSERT_IMPLY(a_hdr_idle, i_clk, i_rst_n, r_in_payload, r_hdr_idx == 3'd0)
    `ASSERT_NEVER(a_pos_sat, i_clk, i_rst_n, r_pos > SIZE_BYTES)

endmodule

// File: rtl/tlfd_queue.sv
// ----------------------------------------------------------------------------
// tlfd_queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlfd_queue
    import tlfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid)

endmodule

// File: rtl/tlfd_back.sv
// ----------------------------------------------------------------------------
// tlfd_back
// Output stage: moves result records from the queue into the output register
// and presents them on the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlfd_back
    import tlfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_result i_q_data,
    output logic    o_pop,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_pop       = i_q_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Only data-byte records may carry a last flag.
    `ASSERT_IMPLY(a_last_only_data, i_clk, i_rst_n, r_valid && r_res.data_last,
        r_res.ev == EV_DATA)
    `ASSERT_IMPLY(a_size_only_resize, i_clk, i_rst_n,
        r_valid && (r_res.columns != 16'd0 || r_res.rows != 16'd0), r_res.ev == EV_RESIZE)

endmodule

// File: rtl/type_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// type_length_frame_deframer
// Splits a type-length framed byte stream into data bytes, resize and ping
// events, and length errors.
// ----------------------------------------------------------------------------
// The block takes one byte per clock on the input channel and gives at most
// one result per byte, which is registered in the queue and then in the
// output register on its way to the output. Each frame is a type byte, a
// 32-bit big-endian length and the payload. Data frames (type 1) pass each
// payload byte straight out, with data_last set on the final one. Resize
// frames (type 2) with at least four payload bytes report columns and rows
// from those bytes when the frame ends; a ping (type 4) reports a reply when
// it ends, even with no payload. Other types are consumed silently. A length
// above the configured length limit gives a length-error event on the last
// header byte, and the next byte starts a new header. Sustained rate is one
// byte per clock: a two-entry queue between the parser and the output
// register absorbs a stall on the result side, so the input is held off
// only once that queue has filled. The length limit resets to 1048576. The
// user must write it through i_cfg_we and i_cfg_wdata while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module type_length_frame_deframer
    import tlfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write.
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // Input byte channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic        o_data_last,
    output logic [15:0] o_columns,
    output logic [15:0] o_rows
);

    logic    w_accept;
    logic    w_push;
    t_result w_push_data;
    logic    w_full;
    logic    w_pop;
    logic    w_q_valid;
    t_result w_q_data;
    t_result w_res;

    // The input is held off only while the queue is full, a registered state,
    // so the stall carries no path from the result side.
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    tlfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_in_byte   (i_in_byte),
        .o_push      (w_push),
        .o_result    (w_push_data)
    );

    tlfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data)
    );

    tlfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    assign o_event_res = w_res.ev;
    assign o_data_byte = w_res.data_byte;
    assign o_data_last = w_res.data_last;
    assign o_columns   = w_res.columns;
    assign o_rows      = w_res.rows;

endmodule
